### hw/rtl/dll_pkg.sv
// Shared types and constants for the doubly linked list engine.
package dll_pkg;

   localparam int CMD_W    = 3;
   localparam int FIELD_W  = 10;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT   = 3'd0,
      CMD_INSERT_AFTER = 3'd1,
      CMD_INSERT_BEFORE = 3'd2,
      CMD_ERASE        = 3'd3,
      CMD_FIND         = 3'd4,
      CMD_READ         = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_BAD  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_LOOK  = 3'd1,
      S_LINK  = 3'd2,
      S_FIND  = 3'd3,
      S_CLEAR = 3'd4
   } state_type;

endpackage

### hw/rtl/doubly_linked_list_engine_core.sv
// Top level of the doubly linked list engine: command sequencer over the node pool memories.
//
//   channel   ports                                   handshake
//   command   req_cmd, req_position, req_item_value   taken when start is high and busy is low
//   result    rsp_status, rsp_node, rsp_node_value,   one word per command, shown for one
//             rsp_node_prev, rsp_node_next            cycle while rsp_valid is high
//
// Erase, read, refused commands and unused codes pass through S_LOOK alone before idle again.
// Inserts add S_LINK after the link memory read and write; find adds S_FIND to read the node.
// The result word appears in the cycle after the last busy cycle; the receiver cannot stall.
// After reset the engine stays busy in S_CLEAR while it zeroes every value map entry.
// Nodes need no clearing: they are checked against the allocation count, and a value map
// entry is trusted only when it names a live node holding that value.
module doubly_linked_list_engine_core
   import dll_pkg::*;
#(
   parameter int NODES       = 1024,
   parameter int VALUE_RANGE = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [FIELD_W-1:0]  req_position,
   input  logic [FIELD_W-1:0]  req_item_value,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_node,
   output logic [FIELD_W-1:0]  rsp_node_value,
   output logic [FIELD_W-1:0]  rsp_node_prev,
   output logic [FIELD_W-1:0]  rsp_node_next
);

   localparam int NW = $clog2(NODES);
   localparam int VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
   localparam int DW = FIELD_W + 1;

   state_type state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [FIELD_W-1:0] pos_ff, val_ff;
   logic [NW-1:0]      alloc_ff, alloc_in;
   logic [NW-1:0]      sent_next_ff, sent_next_in, sent_prev_ff, sent_prev_in;
   logic [NW-1:0]      a_ff, b_ff;
   logic [VW-1:0]      clr_ff, clr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [FIELD_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [FIELD_W-1:0]  rsp_prev_ff, rsp_prev_in;
   logic [FIELD_W-1:0]  rsp_next_ff, rsp_next_in;

   logic          accept;
   logic          node_we, node_re, prev_we, next_we, map_we;
   logic [NW-1:0] node_wa, node_ra, prev_wa, next_wa;
   logic [DW-1:0] node_wd, node_rd;
   logic [NW-1:0] prev_wd, next_wd, prev_rd, next_rd, map_rd;
   logic [VW-1:0] map_wa;
   logic [NW-1:0] map_wd;

   logic          p_zero, anchor_ok, full, val_in_map, ins_go, find_hit;
   logic [NW-1:0] p_idx, p_prev, p_next, new_node, link_a, link_b;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign p_idx      = NW'(pos_ff);
   assign p_zero     = (pos_ff == '0);
   assign anchor_ok  = (32'(pos_ff) < NODES) &&
                       (p_zero || ((32'(pos_ff) <= 32'(alloc_ff)) && node_rd[DW-1]));
   assign p_prev     = p_zero ? sent_prev_ff : prev_rd;
   assign p_next     = p_zero ? sent_next_ff : next_rd;
   assign full       = (alloc_ff == NW'(NODES - 1));
   assign new_node   = alloc_ff + 1'b1;
   assign val_in_map = (32'(val_ff) < VALUE_RANGE);
   assign find_hit   = val_in_map && (map_rd != '0) && (map_rd <= alloc_ff) &&
                       node_rd[DW-1] && (node_rd[FIELD_W-1:0] == val_ff);

   always_comb begin
      link_a = '0;
      link_b = sent_next_ff;
      ins_go = 1'b0;
      case (cmd_ff)
         CMD_PUSH_FRONT: begin
            ins_go = !full;
         end
         CMD_INSERT_AFTER: begin
            link_a = p_idx;
            link_b = p_next;
            ins_go = anchor_ok && !full;
         end
         CMD_INSERT_BEFORE: begin
            link_a = p_prev;
            link_b = p_idx;
            ins_go = anchor_ok && !full;
         end
         default: begin
            ins_go = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (ins_go) begin
               state_in = S_LINK;
            end else if (cmd_ff == CMD_FIND) begin
               state_in = S_FIND;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LINK:  state_in = S_IDLE;
         S_FIND:  state_in = S_IDLE;
         S_CLEAR: begin
            if (clr_ff == VW'(VALUE_RANGE - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      node_re = 1'b0;
      node_ra = NW'(req_position);
      node_we = 1'b0;
      node_wa = p_idx;
      node_wd = {1'b0, node_rd[FIELD_W-1:0]};
      prev_we = 1'b0;
      prev_wa = link_b;
      prev_wd = new_node;
      next_we = 1'b0;
      next_wa = link_a;
      next_wd = new_node;
      map_we  = 1'b0;
      map_wa  = VW'(val_ff);
      map_wd  = new_node;
      clr_in  = clr_ff;
      alloc_in     = alloc_ff;
      sent_next_in = sent_next_ff;
      sent_prev_in = sent_prev_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_node_in   = '0;
      rsp_value_in  = '0;
      rsp_prev_in   = '0;
      rsp_next_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            node_re = accept;
         end
         S_LOOK: begin
            if (ins_go) begin
               if (link_a == '0) begin
                  sent_next_in = new_node;
               end else begin
                  next_we = 1'b1;
               end
               if (link_b == '0) begin
                  sent_prev_in = new_node;
               end else begin
                  prev_we = 1'b1;
               end
            end else begin
               case (cmd_ff) inside
                  CMD_PUSH_FRONT, CMD_INSERT_AFTER, CMD_INSERT_BEFORE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = anchor_ok || (cmd_ff == CMD_PUSH_FRONT) ?
                                     STAT_FULL : STAT_BAD;
                  end
                  CMD_ERASE: begin
                     rsp_valid_in = 1'b1;
                     if (p_zero || !anchor_ok) begin
                        rsp_status_in = STAT_BAD;
                     end else begin
                        rsp_node_in = pos_ff;
                        node_we     = 1'b1;
                        next_wa     = p_prev;
                        next_wd     = p_next;
                        prev_wa     = p_next;
                        prev_wd     = p_prev;
                        if (p_prev == '0) begin
                           sent_next_in = p_next;
                        end else begin
                           next_we = 1'b1;
                        end
                        if (p_next == '0) begin
                           sent_prev_in = p_prev;
                        end else begin
                           prev_we = 1'b1;
                        end
                     end
                  end
                  CMD_FIND: begin
                     node_re = 1'b1;
                     node_ra = map_rd;
                  end
                  CMD_READ: begin
                     rsp_valid_in = 1'b1;
                     if (anchor_ok) begin
                        rsp_node_in  = pos_ff;
                        rsp_value_in = p_zero ? '0 : node_rd[FIELD_W-1:0];
                        rsp_prev_in  = FIELD_W'(p_prev);
                        rsp_next_in  = FIELD_W'(p_next);
                     end else begin
                        rsp_status_in = STAT_BAD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_BAD;
                  end
               endcase
            end
         end
         S_LINK: begin
            node_we  = 1'b1;
            node_wa  = new_node;
            node_wd  = {1'b1, val_ff};
            next_we  = 1'b1;
            next_wa  = new_node;
            next_wd  = b_ff;
            prev_we  = 1'b1;
            prev_wa  = new_node;
            prev_wd  = a_ff;
            map_we   = val_in_map;
            alloc_in = new_node;
            rsp_valid_in = 1'b1;
            rsp_node_in  = FIELD_W'(new_node);
         end
         S_FIND: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = find_hit ? FIELD_W'(map_rd) : '0;
         end
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            map_wd = '0;
            clr_in = clr_ff + 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         alloc_ff     <= '0;
         sent_next_ff <= '0;
         sent_prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_ff     <= alloc_in;
         sent_next_ff <= sent_next_in;
         sent_prev_ff <= sent_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
      if (state_ff == S_LOOK) begin
         a_ff <= link_a;
         b_ff <= link_b;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_next_ff   <= rsp_next_in;
   end

   dll_ram #(.DEPTH(NODES), .WIDTH(DW)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_en   (node_re),
      .rd_addr (node_ra),
      .rd_data (node_rd)
   );

   dll_ram #(.DEPTH(NODES), .WIDTH(NW)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (accept),
      .rd_addr (NW'(req_position)),
      .rd_data (prev_rd)
   );

   dll_ram #(.DEPTH(NODES), .WIDTH(NW)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (accept),
      .rd_addr (NW'(req_position)),
      .rd_data (next_rd)
   );

   dll_ram #(.DEPTH(VALUE_RANGE), .WIDTH(NW)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_en   (accept),
      .rd_addr (VW'(req_item_value)),
      .rd_data (map_rd)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node       = rsp_node_ff;
   assign rsp_node_value = rsp_value_ff;
   assign rsp_node_prev  = rsp_prev_ff;
   assign rsp_node_next  = rsp_next_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy))
      else $error("Result word without a command in progress.");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(alloc_ff) <= NODES - 1)
      else $error("Allocation count ran past the pool.");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ($past(state_ff) == S_LINK)) |->
         (alloc_ff == NW'($past(alloc_ff) + 1'b1)))
      else $error("Insert did not advance the allocation count by one.");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(node_we || prev_we || next_we || map_we))
      else $error("Memory write while no command is in progress.");

endmodule

### hw/rtl/dll_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module dll_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
